@@ rtl/tmg_pkg.sv @@
// ----------------------------------------------------------------------------
// Tone and melody generator package
// Shared constants, command codes, queue entry and state types.
// ----------------------------------------------------------------------------
package tmg_pkg;

  // Default depth of the note table.
  localparam int NOTES_DEFAULT = 256;

  // Command codes as they arrive on the func field.
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_TONE  = 3'd2;
  localparam logic [2:0] FUNC_TRACK = 3'd3;
  localparam logic [2:0] FUNC_STOP  = 3'd4;

  // Numerator of the half period division, in microseconds.
  localparam logic [18:0] HALF_PERIOD_NUM = 19'd500000;
  localparam int          DIV_STEPS       = 19;
  localparam int          DIV_CNT_W       = 5;

  // Microsecond prescaler wraps after this count.
  localparam logic [9:0]  US_PER_MS_LAST  = 10'd999;
  // Saturation point of the time since the last toggle.
  localparam logic [18:0] SINCE_MAX       = 19'h7FFFF;

  localparam logic [7:0]  VOLUME_RESET    = 8'd255;

  // Command classes produced by the front end.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_WRITE,
    CMD_TONE,
    CMD_TONE_OFF,
    CMD_TRACK,
    CMD_STOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  idx;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [8:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] len;
  } note_t;

  typedef struct packed {
    logic        start;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [18:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_EVAL,
    ST_NOTE_RD,
    ST_NOTE_USE,
    ST_DIV_WAIT,
    ST_RESULT
  } back_state_t;

endpackage

@@ rtl/tmg_front.sv @@
// ----------------------------------------------------------------------------
// Tone and melody generator front end
// Takes command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tmg_front
  import tmg_pkg::*;
#(
  parameter int MAX_NOTES = NOTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  note_index,
  input  logic [15:0] frequency_hz,
  input  logic [15:0] duration_ms,
  input  logic [8:0]  track_length,
  output logic        q_valid,
  output cmd_t        q_data,
  input  logic        q_pop
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       push;
  cmd_t       decoded;

  always_comb begin
    decoded      = '0;
    decoded.idx  = note_index;
    decoded.freq = frequency_hz;
    decoded.dur  = duration_ms;
    if (int'(track_length) > MAX_NOTES) begin
      decoded.count = 9'(MAX_NOTES);
    end else begin
      decoded.count = track_length;
    end
    case (func)
      FUNC_TICK: begin
        decoded.kind = CMD_TICK;
      end
      FUNC_WRITE: begin
        decoded.kind = (int'(note_index) < MAX_NOTES) ? CMD_WRITE : CMD_NONE;
      end
      FUNC_TONE: begin
        // A silent or zero-length tone only stops the sound.
        if (frequency_hz == 16'd0 || duration_ms == 16'd0) begin
          decoded.kind = CMD_TONE_OFF;
        end else begin
          decoded.kind = CMD_TONE;
        end
      end
      FUNC_TRACK: begin
        // An empty track behaves exactly as a stop.
        decoded.kind = (track_length == 9'd0) ? CMD_STOP : CMD_TRACK;
      end
      FUNC_STOP: begin
        decoded.kind = CMD_STOP;
      end
      default: begin
        decoded.kind = CMD_NONE;
      end
    endcase
  end

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = entry[rd_ptr];
  assign fill_next = fill + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

endmodule

@@ rtl/tmg_div.sv @@
// ----------------------------------------------------------------------------
// Tone and melody generator half period divider
// Restoring divider, one quotient bit a cycle, of a fixed numerator.
// ----------------------------------------------------------------------------
module tmg_div
  import tmg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          rem;
  logic [15:0]          dvsr;
  logic [18:0]          num;
  logic [18:0]          quot;
  logic [16:0]          trial;
  logic                 fits;

  assign trial = {rem, num[18]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvsr <= req.divisor;
      num  <= HALF_PERIOD_NUM;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= {num[17:0], 1'b0};
      quot <= {quot[17:0], fits};
      if (fits) begin
        rem <= 16'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[15:0];
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

@@ rtl/tmg_back.sv @@
// ----------------------------------------------------------------------------
// Tone and melody generator back end
// Executes queued commands: time base, note table, wave and result register.
// ----------------------------------------------------------------------------
module tmg_back
  import tmg_pkg::*;
#(
  parameter int MAX_NOTES = NOTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  input  logic [7:0] volume,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pin_level,
  output logic       track_playing,
  output logic       tone_active
);

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  back_state_t state, state_next;

  logic [9:0]  ps, ps_next;
  logic [31:0] now_ms, now_ms_next;
  logic [31:0] end_ms, end_ms_next;
  logic [15:0] cur_freq, cur_freq_next;
  logic [18:0] half, half_next;
  logic [18:0] since, since_next;
  logic        wave, wave_next;
  logic        active, active_next;
  logic [8:0]  pos, pos_next;
  logic [8:0]  count, count_next;
  cmd_t        cmd, cmd_next;

  note_t       mem [MAX_NOTES];
  note_t       rd_note;
  logic        mem_we;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        res_load;
  logic        res_valid;
  logic        ended;
  logic        can_toggle;
  logic [9:0]  pos_inc;

  tmg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign ended      = (now_ms >= end_ms);
  assign can_toggle = (since >= half);
  assign pos_inc    = {1'b0, pos} + 10'd1;

  always_comb begin
    state_next    = state;
    ps_next       = ps;
    now_ms_next   = now_ms;
    end_ms_next   = end_ms;
    cur_freq_next = cur_freq;
    half_next     = half;
    since_next    = since;
    wave_next     = wave;
    active_next   = active;
    pos_next      = pos;
    count_next    = count;
    cmd_next      = cmd;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    div_req       = '0;
    res_load      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_next   = q_data;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_RESULT;
        case (cmd.kind)
          CMD_TICK: begin
            if (ps == US_PER_MS_LAST) begin
              ps_next     = '0;
              now_ms_next = now_ms + 32'd1;
            end else begin
              ps_next = ps + 10'd1;
            end
            if (since != SINCE_MAX) begin
              since_next = since + 19'd1;
            end
            state_next = ST_TICK_EVAL;
          end
          CMD_WRITE: begin
            mem_we = 1'b1;
          end
          CMD_TONE: begin
            cur_freq_next   = cmd.freq;
            end_ms_next     = now_ms + {16'd0, cmd.dur};
            since_next      = '0;
            wave_next       = 1'b0;
            active_next     = 1'b0;
            div_req.start   = 1'b1;
            div_req.divisor = cmd.freq;
            state_next      = ST_DIV_WAIT;
          end
          CMD_TONE_OFF: begin
            cur_freq_next = '0;
            end_ms_next   = '0;
            half_next     = '0;
            wave_next     = 1'b0;
          end
          CMD_TRACK: begin
            cur_freq_next = '0;
            end_ms_next   = '0;
            half_next     = '0;
            wave_next     = 1'b0;
            count_next    = cmd.count;
            pos_next      = '0;
            active_next   = 1'b1;
            state_next    = ST_NOTE_RD;
          end
          CMD_STOP: begin
            active_next   = 1'b0;
            cur_freq_next = '0;
            end_ms_next   = '0;
            half_next     = '0;
            wave_next     = 1'b0;
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      ST_TICK_EVAL: begin
        state_next = ST_RESULT;
        if (active) begin
          if (ended) begin
            if (pos_inc >= {1'b0, count}) begin
              // Last note done: the track stops.
              active_next   = 1'b0;
              cur_freq_next = '0;
              end_ms_next   = '0;
              half_next     = '0;
              wave_next     = 1'b0;
            end else begin
              pos_next   = pos_inc[8:0];
              state_next = ST_NOTE_RD;
            end
          end else if (cur_freq != 16'd0 && half != 19'd0) begin
            if (can_toggle) begin
              since_next = since - half;
              wave_next  = !wave;
            end
          end else begin
            wave_next = 1'b0;
          end
        end else if (cur_freq != 16'd0) begin
          if (ended) begin
            cur_freq_next = '0;
            end_ms_next   = '0;
            half_next     = '0;
            wave_next     = 1'b0;
          end else if (half != 19'd0 && can_toggle) begin
            since_next = since - half;
            wave_next  = !wave;
          end
        end else begin
          wave_next = 1'b0;
        end
      end

      ST_NOTE_RD: begin
        state_next = ST_NOTE_USE;
      end

      ST_NOTE_USE: begin
        end_ms_next = now_ms + {16'd0, rd_note.len};
        wave_next   = 1'b0;
        if (rd_note.freq == 16'd0) begin
          // A rest: silence without restarting the toggle timer.
          cur_freq_next = '0;
          half_next     = '0;
          state_next    = ST_RESULT;
        end else begin
          cur_freq_next   = rd_note.freq;
          since_next      = '0;
          div_req.start   = 1'b1;
          div_req.divisor = rd_note.freq;
          state_next      = ST_DIV_WAIT;
        end
      end

      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          half_next  = div_rsp.quotient;
          state_next = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!res_valid || !out_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps       <= '0;
      now_ms   <= '0;
      end_ms   <= '0;
      cur_freq <= '0;
      half     <= '0;
      since    <= '0;
      wave     <= 1'b0;
      active   <= 1'b0;
      pos      <= '0;
      count    <= '0;
    end else begin
      ps       <= ps_next;
      now_ms   <= now_ms_next;
      end_ms   <= end_ms_next;
      cur_freq <= cur_freq_next;
      half     <= half_next;
      since    <= since_next;
      wave     <= wave_next;
      active   <= active_next;
      pos      <= pos_next;
      count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

  // Note table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.idx)] <= '{freq: cmd.freq, len: cmd.dur};
    end
    rd_note <= mem[AW'(pos)];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pin_level     <= wave ? volume : 8'd0;
      track_playing <= active;
      tone_active   <= (cur_freq != 16'd0);
    end
  end

  assign out_valid = res_valid;

endmodule

@@ rtl/tone_and_melody_generator.sv @@
// ----------------------------------------------------------------------------
// Tone and melody generator
// Square-wave buzzer driver with a microsecond time base and note sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                  Direction  Beat
//   command   in_valid/in_stall, func .. track_length  in         one command
//   result    out_valid/out_stall, pin_level ..        out        one per command
//   volume    volume_we, volume_wdata                  in         one write
//
// A result beat is offered once its command has been taken and executed; a
// tone waits on the serial divider (19 quotient bits), and a tick that moves
// a track on to a sounding note waits on the note table read and then on the
// divider.
// Reset is synchronous and active high; it clears the time base, the wave
// and the sequencer, sets the volume to full and leaves the note table as is.
// The front end takes up to two further command beats while the back end
// works or while a result beat waits behind a stalled output.
//
module tone_and_melody_generator
  import tmg_pkg::*;
#(
  parameter int MAX_NOTES = NOTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  note_index,
  input  logic [15:0] frequency_hz,
  input  logic [15:0] duration_ms,
  input  logic [8:0]  track_length,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pin_level,
  output logic        track_playing,
  output logic        tone_active,

  input  logic        volume_we,
  input  logic [7:0]  volume_wdata
);

  logic       q_valid;
  logic       q_pop;
  cmd_t       q_data;
  logic [7:0] volume;

  // The user must write the volume register only while the block is idle, so
  // the back end may sample it when it builds each result beat. The block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (volume_we) begin
      volume <= volume_wdata;
    end
  end

  // The front end decodes each command beat into a class, folding the
  // special cases (silent tone, empty track, out-of-range write) into
  // plain operations, and queues it.
  tmg_front #(
    .MAX_NOTES (MAX_NOTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .note_index   (note_index),
    .frequency_hz (frequency_hz),
    .duration_ms  (duration_ms),
    .track_length (track_length),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  // The back end runs one command at a time and owns all timing state,
  // the note table and the result register.
  tmg_back #(
    .MAX_NOTES (MAX_NOTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .volume        (volume),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pin_level     (pin_level),
    .track_playing (track_playing),
    .tone_active   (tone_active)
  );

endmodule
